[hw/rtl/lrukv_pkg.sv]
package lrukv_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RANK_W   = IDX_W;
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int CFG_W    = 5;
  localparam int DATA_W   = 32;

  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;  // -1

  // Controller to datapath
  typedef struct packed {
    logic capture;  // load the request registers
    logic match;    // register lookup, free slot and victim
    logic commit;   // update entries and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_space;  // result register is empty or being drained
  } status_t;

endpackage

[hw/rtl/lru_key_value_cache.sv]
// Sequence: the request is captured, the lookup is registered, and the result
//   register loads at commit, which waits while the consumer still holds it.
// Requests: a new one is taken only after the last has committed; each passes
//   three steps (capture, lookup, commit), all sharing the one flip-flop entry store.
// Reset: valid bits, recency ranks, occupancy and result valid clear;
//   entries_in_use returns to 16; keys and values are not cleared.
module lru_key_value_cache (
  input  logic                            clk,
  input  logic                            rst,
  // configuration: entries_in_use
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrukv_pkg::CFG_W-1:0]     cfg_data,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic signed [lrukv_pkg::DATA_W-1:0] key,
  input  logic signed [lrukv_pkg::DATA_W-1:0] value,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic signed [lrukv_pkg::DATA_W-1:0] read_value,
  output logic                            evicted,
  output logic signed [lrukv_pkg::DATA_W-1:0] evicted_key
);
  import lrukv_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence each transaction: capture the request, register the lookup,
  // then commit the store update and the result together.
  lrukv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the entries: parallel key compare, lowest free slot, and the victim
  // found as the valid entry ranked occupancy minus one (ranks stay a
  // permutation of 0 .. occupancy-1 over the valid entries).
  lrukv_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .func        (func),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key),
    .cmd         (cmd),
    .status      (status)
  );

`ifndef SYNTHESIS
  // the controller drops ready for the rest of the transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after request accept");

  // never overwrite a result the consumer has not taken
  a_commit_space: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_space)
    else $error("commit into a full result register");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not raise out_valid");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.match, cmd.commit}))
    else $error("overlapping datapath commands");
`endif

endmodule

[hw/rtl/lrukv_ctrl.sv]
module lrukv_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lrukv_pkg::status_t status,
  output lrukv_pkg::cmd_t    cmd
);
  import lrukv_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_COMMIT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.match   = (state == S_MATCH);
    cmd.commit  = (state == S_COMMIT) && status.out_space;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_MATCH;
        end
        S_MATCH: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          // hold until the result register can take the transaction
          if (status.out_space) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/lrukv_datapath.sv]
module lrukv_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrukv_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            func,
  input  logic signed [lrukv_pkg::DATA_W-1:0] key,
  input  logic signed [lrukv_pkg::DATA_W-1:0] value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic signed [lrukv_pkg::DATA_W-1:0] read_value,
  output logic                            evicted,
  output logic signed [lrukv_pkg::DATA_W-1:0] evicted_key,
  input  lrukv_pkg::cmd_t                 cmd,
  output lrukv_pkg::status_t              status
);
  import lrukv_pkg::*;

  // Entry store
  logic [CAPACITY-1:0] entry_valid;
  logic [DATA_W-1:0]   entry_key   [CAPACITY];
  logic [DATA_W-1:0]   entry_value [CAPACITY];
  logic [RANK_W-1:0]   recency_rank [CAPACITY];
  logic [OCC_W-1:0]    occupied_count;
  logic [CFG_W-1:0]    entries_in_use;

  // Request registers
  logic              req_func;
  logic [DATA_W-1:0] req_key;
  logic [DATA_W-1:0] req_value;

  // Lookup registers
  logic              m_present;
  logic              m_fill;
  logic [IDX_W-1:0]  m_target;
  logic [RANK_W-1:0] m_old_rank;
  logic [DATA_W-1:0] m_read;
  logic [DATA_W-1:0] m_victim_key;

  // Lookup logic
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] victim_vec;
  logic [IDX_W-1:0]    found_idx;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    victim_idx;
  logic [OCC_W-1:0]    occ_m1;
  logic [OCC_W-1:0]    limit;
  logic                present;
  logic                fill;
  logic                touch;

  assign cfg_ready = 1'b1;
  assign status.out_space = !out_valid || out_ready;

  always_comb begin
    if (entries_in_use == '0) begin
      limit = OCC_W'(1);
    end else if (32'(entries_in_use) > CAPACITY) begin
      limit = OCC_W'(CAPACITY);
    end else begin
      limit = OCC_W'(entries_in_use);
    end
  end

  assign occ_m1 = occupied_count - OCC_W'(1);

  always_comb begin
    found_idx  = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      match_vec[i]  = entry_valid[i] && (entry_key[i] == req_key);
      victim_vec[i] = entry_valid[i] && (recency_rank[i] == RANK_W'(occ_m1));
      if (match_vec[i])    found_idx  = IDX_W'(i);
      if (!entry_valid[i]) free_idx   = IDX_W'(i);
      if (victim_vec[i])   victim_idx = IDX_W'(i);
    end
    present = |match_vec;
    fill    = (occupied_count < limit);
  end

  // a get miss leaves the store untouched
  assign touch = m_present || req_func;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid    <= '0;
      occupied_count <= '0;
      entries_in_use <= CFG_RESET;
      out_valid      <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        recency_rank[i] <= '0;
      end
    end else begin
      if (cfg_valid) entries_in_use <= cfg_data;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit && touch) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (IDX_W'(i) == m_target) begin
            recency_rank[i] <= '0;
          end else if (entry_valid[i] &&
                       ((!m_present && m_fill) || (recency_rank[i] < m_old_rank))) begin
            recency_rank[i] <= recency_rank[i] + RANK_W'(1);
          end
        end
        if (req_func && !m_present && m_fill) begin
          entry_valid[m_target] <= 1'b1;
          occupied_count        <= occupied_count + OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func  <= func;
      req_key   <= key;
      req_value <= value;
    end
    if (cmd.match) begin
      m_present    <= present;
      m_fill       <= fill;
      m_target     <= present ? found_idx : (fill ? free_idx : victim_idx);
      m_old_rank   <= present ? recency_rank[found_idx] : RANK_W'(occ_m1);
      m_read       <= entry_value[found_idx];
      m_victim_key <= entry_key[victim_idx];
    end
    if (cmd.commit) begin
      if (req_func) begin
        entry_value[m_target] <= req_value;
        if (!m_present) entry_key[m_target] <= req_key;
      end
      hit         <= m_present;
      read_value  <= req_func ? '0 : (m_present ? m_read : MISS_VALUE);
      evicted     <= req_func && !m_present && !m_fill;
      evicted_key <= (req_func && !m_present && !m_fill) ? m_victim_key : '0;
    end
  end

endmodule
